@@ rtl/time_seeded_rotate_mix_prng_macros.svh @@
// Assertion macros used by the mixer controller, tsrm_ctrl.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef TIME_SEEDED_ROTATE_MIX_PRNG_MACROS_SVH
`define TIME_SEEDED_ROTATE_MIX_PRNG_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TSRM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsrm: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TSRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsrm: next-cycle check failed");

`endif

@@ rtl/tsrm_pkg.sv @@
// Shared types, constants and the rotate helper for the rotate-mix generator.
// No dependencies; used by tsrm_ctrl, tsrm_dp and the top level.
package tsrm_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ROUND_W = 6;

    localparam logic [WORD_W-1:0] SEED_RESET = 32'h0def_aced;
    localparam logic [WORD_W-1:0] SEED_SUB_K = 32'h87e9_c96b;
    localparam logic [WORD_W-1:0] SEED_ADD_K = 32'h9a72_e90f;
    // Fewest rounds minus one; the time word's low five bits add to it.
    localparam logic [ROUND_W-1:0] ROUND_BASE_M1 = 6'd31;

    // One round is split into four sub-steps, one rotate and one add, subtract or XOR each.
    typedef enum logic [1:0] {
        PH_SEED_MOVE = 2'd0,
        PH_WORD_MIX  = 2'd1,
        PH_SEED_MIX  = 2'd2,
        PH_WORD_FOLD = 2'd3
    } phase_t;

    typedef struct packed {
        logic   load;
        logic   step;
        logic   commit;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic [ROUND_W-1:0] rounds_m1;
    } status_t;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                                input logic [4:0] n);
        logic [2*WORD_W-1:0] d;
        d = {v, v} >> n;
        return d[WORD_W-1:0];
    endfunction

endpackage

@@ rtl/time_seeded_rotate_mix_prng.sv @@
// Top level of the time-seeded rotate-mix generator.
// Depends on tsrm_pkg, tsrm_ctrl and tsrm_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------
//  input   | in_valid / in_stall  | time_value  [31:0]
//  output  | out_valid / out_stall| random_word [31:0]
//
// Each transaction runs R = (time_value & 31) + 32 rounds, 32 to 63.
// A round takes four sub-steps in the shared datapath, each one rotate
// and one add, subtract or XOR.
// After reset the seed is 0x0defaced and the block is ready at once.
// A stalled full result register holds the finished word in the datapath;
// the next input is taken once the word has moved into the register.
module time_seeded_rotate_mix_prng (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] time_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] random_word
);

    tsrm_pkg::cmd_t    cmd;
    tsrm_pkg::status_t status;

    // Sequence rounds and phases, drive both handshakes.
    tsrm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold working word and persistent seed; one sub-step a cycle while running.
    tsrm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .time_value  (time_value),
        .status      (status),
        .random_word (random_word)
    );

endmodule

@@ rtl/tsrm_dp.sv @@
// Datapath of the rotate-mix generator: working word, seed, result register.
// Depends on tsrm_pkg; driven by tsrm_ctrl through tsrm_pkg::cmd_t.
module tsrm_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tsrm_pkg::cmd_t                   cmd,
    input  logic [tsrm_pkg::WORD_W-1:0]      time_value,
    output tsrm_pkg::status_t                status,
    output logic [tsrm_pkg::WORD_W-1:0]      random_word
);

    logic [tsrm_pkg::WORD_W-1:0]  w_reg, w_next;
    logic [tsrm_pkg::WORD_W-1:0]  s_reg, s_next;
    logic [tsrm_pkg::WORD_W-1:0]  rot;
    logic [tsrm_pkg::ROUND_W-1:0] rounds_m1_reg;
    logic [tsrm_pkg::WORD_W-1:0]  result_reg;

    always_comb
    begin
        w_next = w_reg;
        s_next = s_reg;
        rot    = '0;
        case (cmd.phase)
            tsrm_pkg::PH_SEED_MOVE:
            begin
                rot    = tsrm_pkg::rotr(w_reg, s_reg[4:0]);
                w_next = rot;
                s_next = rot[0] ? s_reg - tsrm_pkg::SEED_SUB_K
                                : s_reg + tsrm_pkg::SEED_ADD_K;
            end
            tsrm_pkg::PH_WORD_MIX:
            begin
                rot    = tsrm_pkg::rotr(w_reg, s_reg[25:21]);
                w_next = s_reg[2] ? (rot ^ s_reg) : (rot - s_reg);
            end
            tsrm_pkg::PH_SEED_MIX:
            begin
                rot    = tsrm_pkg::rotr(s_reg, w_reg[20:16]);
                s_next = w_reg[0] ? (rot + w_reg) : (rot ^ w_reg);
            end
            tsrm_pkg::PH_WORD_FOLD:
            begin
                rot = tsrm_pkg::rotr(w_reg, s_reg[23:19]);
                if (s_reg[4])
                begin
                    w_next = rot + s_reg;
                end
                else
                begin
                    w_next = rot;
                    s_next = s_reg - rot;
                end
            end
            default:
            begin
                w_next = w_reg;
            end
        endcase
    end

    // Seed persists across transactions, so it takes the reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= tsrm_pkg::SEED_RESET;
        end
        else if (cmd.step)
        begin
            s_reg <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg         <= time_value;
            rounds_m1_reg <= tsrm_pkg::ROUND_BASE_M1
                             + {1'b0, time_value[4:0]};
        end
        else if (cmd.step)
        begin
            w_reg <= w_next;
        end
        if (cmd.commit)
        begin
            result_reg <= w_reg;
        end
    end

    assign status.rounds_m1 = rounds_m1_reg;
    assign random_word      = result_reg;

endmodule

@@ rtl/tsrm_ctrl.sv @@
// Controller of the rotate-mix generator: handshakes, round and phase counts.
// Depends on tsrm_pkg and time_seeded_rotate_mix_prng_macros.svh.
`include "time_seeded_rotate_mix_prng_macros.svh"

module tsrm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  tsrm_pkg::status_t status,
    output tsrm_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    tsrm_pkg::phase_t             phase_reg, phase_next;
    logic [tsrm_pkg::ROUND_W-1:0] round_reg, round_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        round_next     = round_reg;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        cmd.commit     = 1'b0;
        cmd.phase      = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = tsrm_pkg::PH_SEED_MOVE;
                    round_next = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.step   = 1'b1;
                phase_next = tsrm_pkg::phase_t'(phase_reg + 2'd1);
                if (phase_reg == tsrm_pkg::PH_WORD_FOLD)
                begin
                    if (round_reg == status.rounds_m1)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        round_next = round_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                // Hold the finished word until the result register frees up.
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= tsrm_pkg::PH_SEED_MOVE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `TSRM_ASSERT_NEXT(a_accept_starts_run, in_valid && !in_stall, state_reg == S_RUN)
    `TSRM_ASSERT_SAME(a_commit_needs_room, cmd.commit, out_valid_reg == 1'b0 || !out_stall)
    `TSRM_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid_reg)
    `TSRM_ASSERT_SAME(a_round_in_range, state_reg == S_RUN, round_reg <= status.rounds_m1)

endmodule

@@ verif/tsrm_mix_checker.sv @@
// Checker for the rotate-mix generator: predicts each random word from the time word.
// Watches both valid/stall channels of time_seeded_rotate_mix_prng; no other dependencies.
module tsrm_mix_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] time_value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] random_word,
    output int          mismatch_count,
    output int          pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] SEED_AT_RESET = 32'h0def_aced;
    localparam logic [31:0] SEED_DOWN_K   = 32'h87e9_c96b;
    localparam logic [31:0] SEED_UP_K     = 32'h9a72_e90f;
    localparam int unsigned MIN_ROUNDS    = 32;

    typedef struct packed {
        logic [31:0] word;
        logic [31:0] seed;
    } mix_out_t;

    logic [31:0] seed_q;
    logic [31:0] expected_words[$];
    logic [31:0] want_word;
    mix_out_t    mix_res;

    function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
        if (n == 5'd0)
            return v;
        return (v >> n) | (v << (6'd32 - n));
    endfunction

    function automatic mix_out_t mix_time_word(input logic [31:0] tv, input logic [31:0] seed_in);
        logic [31:0] w;
        logic [31:0] s;
        int unsigned n_rounds;
        mix_out_t    res;
        w = tv;
        s = seed_in;
        n_rounds = MIN_ROUNDS + tv[4:0];
        for (int unsigned r = 0; r < n_rounds; r++)
        begin
            w = ror32(w, s[4:0]);
            if (w[0])
                s = s - SEED_DOWN_K;
            else
                s = s + SEED_UP_K;
            w = ror32(w, s[25:21]);
            if (s[2])
                w = w ^ s;
            else
                w = w - s;
            s = ror32(s, w[20:16]);
            if (w[0])
                s = s + w;
            else
                s = s ^ w;
            w = ror32(w, s[23:19]);
            if (s[4])
                w = w + s;
            else
                s = s - w;
        end
        res.word = w;
        res.seed = s;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_q = SEED_AT_RESET;
            expected_words.delete();
            mismatch_count <= 0;
            pending_words  <= 0;
        end
        else
        begin
            // retire the oldest expectation before queuing a new one
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected random_word %h", $realtime, random_word);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    if (random_word !== want_word)
                    begin
                        if (mismatch_count < 10)
                            $display("%0t: random_word expected %h actual %h",
                                     $realtime, want_word, random_word);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                mix_res = mix_time_word(time_value, seed_q);
                seed_q  = mix_res.seed;
                expected_words.push_back(mix_res.word);
            end
            pending_words <= expected_words.size();
        end
    end

endmodule

@@ verif/tb_time_seeded_rotate_mix_prng.sv @@
// Testbench top for time_seeded_rotate_mix_prng: clock, reset, stimulus and verdict.
// Depends on the RTL top level and on tsrm_mix_checker for prediction and comparison.
module tb_time_seeded_rotate_mix_prng;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1100;
    // extra wait once the checker has no words pending
    localparam int DRAIN_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] time_value = 32'h0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] random_word;

    int mismatch_count;
    int pending_words;

    // sender burst bookkeeping
    int burst_left = 0;
    int gap_len    = 0;

    // receiver stall pattern
    logic [1:0]  stall_mode = 2'd0;
    logic [15:0] stall_tick = 16'd0;

    always #5 clk = ~clk;

    time_seeded_rotate_mix_prng u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .time_value  (time_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word)
    );

    tsrm_mix_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .time_value     (time_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .random_word    (random_word),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    // Receiver: whenever the low byte of the tick counter wraps, pick a stall behavior among
    // never stall, coin-flip stall, mostly stalled, and a square wave from tick bit 2.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 2'd0;
            stall_tick <= 16'd0;
        end
        else
        begin
            stall_tick <= stall_tick + 16'd1;
            if (stall_tick[7:0] == 8'd0)
                stall_mode <= 2'($urandom_range(0, 3));
            case (stall_mode)
                2'd0: out_stall <= 1'b0;
                2'd1: out_stall <= 1'($urandom_range(0, 1));
                2'd2: out_stall <= ($urandom_range(0, 9) < 8);
                default: out_stall <= stall_tick[2];
            endcase
        end
    end

    // Present one time word and hold it until the transaction completes.
    // Then either keep valid high for the next word or drop it for a random gap.
    task automatic send_time(input logic [31:0] tv);
        in_valid   <= 1'b1;
        time_value <= tv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // Pick a random time word; bias some toward the fewest and the most rounds
    // and toward single-bit patterns so every bit sees both values.
    function automatic logic [31:0] pick_time_word();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: return {raw[31:5], 5'd0};
            1: return {raw[31:5], 5'h1f};
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            default: return raw;
        endcase
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of the time word, fewest and most rounds,
        // alternating patterns, and the same word twice to show the seed carries over.
        send_time(32'h0000_0000);
        send_time(32'hffff_ffff);
        send_time(32'h0000_001f);
        send_time(32'h0000_0020);
        send_time(32'hffff_ffe0);
        send_time(32'h8000_0000);
        send_time(32'h7fff_ffff);
        send_time(32'haaaa_aaaa);
        send_time(32'h5555_5555);
        send_time(32'h0000_0001);
        send_time(32'h0000_0001);
        send_time(32'h1234_5678);
        send_time(32'hdead_beef);
        send_time(32'h0001_0000);
        send_time(32'hfffe_ffff);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_time(pick_time_word());
        in_valid <= 1'b0;

        // let the checker see the last accepted word, then drain
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_words == 0)
            $display("time_seeded_rotate_mix_prng: match");
        else
            $display("time_seeded_rotate_mix_prng: mismatch");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #15_000_000;
        $display("time_seeded_rotate_mix_prng: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tsrm_pkg.sv
rtl/tsrm_dp.sv
rtl/tsrm_ctrl.sv
rtl/time_seeded_rotate_mix_prng.sv
verif/tsrm_mix_checker.sv
verif/tb_time_seeded_rotate_mix_prng.sv
